FILE: design/gbfs_pkg.sv
package gbfs_pkg;

    // Default graph size and fixed field widths.
    localparam int NUM_VERTICES_DEF = 16;
    localparam int MODE_W           = 2;
    localparam int VERTEX_W         = 4;

    // Item kinds carried on the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_QUERY = 2'd2
    } mode_t;

    // Command broadcast to every vertex cell.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_ADD,
        CELL_LOAD,
        CELL_STEP
    } cell_op_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

endpackage

FILE: design/gbfs_cell.sv
module gbfs_cell #(
    parameter int NUM_VERTICES = gbfs_pkg::NUM_VERTICES_DEF,
    parameter int INDEX        = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gbfs_pkg::cell_op_t      op,
    input  logic [NUM_VERTICES-1:0] vec_a,
    input  logic [NUM_VERTICES-1:0] vec_b,
    input  logic                    any_in,
    output logic                    frontier,
    output logic                    visited,
    output logic                    any_out
);
    import gbfs_pkg::*;

    logic [NUM_VERTICES-1:0] row_reg;
    logic [NUM_VERTICES-1:0] row_next;
    logic                    frontier_reg;
    logic                    frontier_next;
    logic                    visited_reg;
    logic                    visited_next;
    logic                    hit;

    // The matrix is symmetric, so this vertex joins the next frontier, if not yet
    // visited, when its own row meets the broadcast selection vector.
    assign hit = |(row_reg & vec_a);

    // Next row and search bits for this vertex.
    always_comb
    begin
        row_next      = row_reg;
        frontier_next = frontier_reg;
        visited_next  = visited_reg;
        unique case (op)
            CELL_CLEAR:
            begin
                row_next = '0;
            end
            CELL_ADD:
            begin
                if (vec_a[INDEX])
                begin
                    row_next = row_next | vec_b;
                end
                if (vec_b[INDEX])
                begin
                    row_next = row_next | vec_a;
                end
            end
            CELL_LOAD:
            begin
                frontier_next = hit;
                visited_next  = hit;
            end
            CELL_STEP:
            begin
                frontier_next = hit & ~visited_reg;
                visited_next  = visited_reg | (hit & ~visited_reg);
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    // Row and search state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            frontier_reg <= 1'b0;
            visited_reg  <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            frontier_reg <= frontier_next;
            visited_reg  <= visited_next;
        end
    end

    // Frontier-occupied flag ripples along the row of cells.
    assign frontier = frontier_reg;
    assign visited  = visited_reg;
    assign any_out  = any_in | frontier_reg;

endmodule

FILE: design/graph_reachability_bfs_top.sv
// Graph reachability by breadth-first search over an adjacency bit matrix.
//
// Input channel (in_valid/in_ready) carries one beat per item: mode,
// first_vertex and second_vertex. Mode clear empties the graph, mode add
// joins the two vertices by an undirected edge, mode query asks whether
// second_vertex lies on a walk of one or more edges from first_vertex.
// Unused mode codes are dropped. Output channel (out_valid/out_ready) gives
// one reachable beat per query.
//
// Clear and add may follow each other back to back.
// A query loads the first frontier in its accept cycle, then expands one
// BFS level per cycle in a row of NUM_VERTICES vertex cells, one cell per
// adjacency row; the result is registered once the frontier runs empty
// and the output register is free. in_ready is low while a search runs.
//
// Reset clears the adjacency matrix and the output valid flag. While the
// receiver stalls, a finished result waits in the output register and clear
// and add beats are still taken; a later query keeps its result in the search
// until the output register frees up.
module graph_reachability_bfs_top #(
    parameter int NUM_VERTICES = gbfs_pkg::NUM_VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gbfs_pkg::MODE_W-1:0]   mode,
    input  logic [gbfs_pkg::VERTEX_W-1:0] first_vertex,
    input  logic [gbfs_pkg::VERTEX_W-1:0] second_vertex,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          reachable
);
    import gbfs_pkg::*;

    state_t                  state_reg;
    state_t                  state_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    reachable_reg;
    logic                    reachable_next;
    logic [NUM_VERTICES-1:0] exit_reg;
    logic [NUM_VERTICES-1:0] exit_next;

    logic [NUM_VERTICES-1:0] sel_a;
    logic [NUM_VERTICES-1:0] sel_b;
    logic [NUM_VERTICES-1:0] vec_a;
    logic [NUM_VERTICES-1:0] frontier_vec;
    logic [NUM_VERTICES-1:0] visited_vec;
    logic [NUM_VERTICES:0]   any_chain;
    cell_op_t                op;
    logic                    accept;
    logic                    out_free;

    // One-hot vertex selects; an index past the graph selects nothing.
    always_comb
    begin
        for (int i = 0; i < NUM_VERTICES; i++)
        begin
            sel_a[i] = (32'(first_vertex) == i);
            sel_b[i] = (32'(second_vertex) == i);
        end
    end

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // During a search the frontier is broadcast; otherwise the entrance.
    assign vec_a = (state_reg == ST_SEARCH) ? frontier_vec : sel_a;

    // Controller: decode items, run the search, load the output register.
    always_comb
    begin
        state_next     = state_reg;
        op             = CELL_HOLD;
        exit_next      = exit_reg;
        reachable_next = reachable_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_CLEAR:
                        begin
                            op = CELL_CLEAR;
                        end
                        MODE_ADD:
                        begin
                            if ((|sel_a) && (|sel_b))
                            begin
                                op = CELL_ADD;
                            end
                        end
                        MODE_QUERY:
                        begin
                            // Out-of-range vertices give an empty start or exit.
                            op         = CELL_LOAD;
                            exit_next  = ((|sel_a) && (|sel_b)) ? sel_b : '0;
                            state_next = ST_SEARCH;
                        end
                        default:
                        begin
                            op = CELL_HOLD;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (any_chain[NUM_VERTICES])
                begin
                    op = CELL_STEP;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    reachable_next = |(visited_vec & exit_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        exit_reg      <= exit_next;
        reachable_reg <= reachable_next;
    end

    // Row of vertex cells.
    assign any_chain[0] = 1'b0;

    for (genvar g = 0; g < NUM_VERTICES; g++)
    begin : g_cell
        gbfs_cell #(
            .NUM_VERTICES (NUM_VERTICES),
            .INDEX        (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (op),
            .vec_a    (vec_a),
            .vec_b    (sel_b),
            .any_in   (any_chain[g]),
            .frontier (frontier_vec[g]),
            .visited  (visited_vec[g]),
            .any_out  (any_chain[g+1])
        );
    end

    assign out_valid = out_valid_reg;
    assign reachable = reachable_reg;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import gbfs_pkg::*;

    localparam int NV             = NUM_VERTICES_DEF;
    localparam int ITEM_TARGET    = 700;
    localparam int DRAIN_CYCLES   = NV + 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int GAP_MAX        = 16;

    // Mode code that the block drops without effect.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // One row of the directed stimulus. When pinned is set, the query answer is fixed in
    // the row instead of coming from the reachability predictor.
    typedef struct packed {
        logic [MODE_W-1:0]   op;
        logic [VERTEX_W-1:0] va;
        logic [VERTEX_W-1:0] vb;
        logic                pinned;
        logic                pin;
    } stim_row_t;

    localparam int DIRECTED_COUNT = 25;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{MODE_QUERY, 4'd0,  4'd0,  1'b1, 1'b0},
        '{MODE_QUERY, 4'd15, 4'd15, 1'b1, 1'b0},
        '{MODE_QUERY, 4'd15, 4'd0,  1'b1, 1'b0},
        '{MODE_SPARE, 4'd15, 4'd15, 1'b0, 1'b0},
        '{MODE_ADD,   4'd0,  4'd15, 1'b0, 1'b0},
        '{MODE_QUERY, 4'd0,  4'd15, 1'b1, 1'b1},
        '{MODE_QUERY, 4'd15, 4'd0,  1'b1, 1'b1},
        '{MODE_QUERY, 4'd0,  4'd0,  1'b1, 1'b1},
        '{MODE_QUERY, 4'd1,  4'd1,  1'b1, 1'b0},
        '{MODE_ADD,   4'd7,  4'd7,  1'b0, 1'b0},
        '{MODE_QUERY, 4'd7,  4'd7,  1'b1, 1'b1},
        '{MODE_QUERY, 4'd7,  4'd0,  1'b1, 1'b0},
        '{MODE_ADD,   4'd15, 4'd0,  1'b0, 1'b0},
        '{MODE_ADD,   4'd15, 4'd1,  1'b0, 1'b0},
        '{MODE_ADD,   4'd1,  4'd2,  1'b0, 1'b0},
        '{MODE_QUERY, 4'd0,  4'd2,  1'b0, 1'b0},
        '{MODE_QUERY, 4'd2,  4'd7,  1'b0, 1'b0},
        '{MODE_CLEAR, 4'd0,  4'd0,  1'b0, 1'b0},
        '{MODE_QUERY, 4'd0,  4'd15, 1'b1, 1'b0},
        '{MODE_QUERY, 4'd7,  4'd7,  1'b1, 1'b0},
        '{MODE_SPARE, 4'd0,  4'd0,  1'b0, 1'b0},
        '{MODE_ADD,   4'd5,  4'd10, 1'b0, 1'b0},
        '{MODE_QUERY, 4'd10, 4'd5,  1'b1, 1'b1},
        '{MODE_CLEAR, 4'd15, 4'd15, 1'b0, 1'b0},
        '{MODE_QUERY, 4'd5,  4'd10, 1'b1, 1'b0}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [MODE_W-1:0]   mode;
    logic [VERTEX_W-1:0] first_vertex;
    logic [VERTEX_W-1:0] second_vertex;
    logic                out_valid;
    logic                out_ready;
    logic                reachable;

    // Fixed answer that travels with the beat on the input channel.
    logic                pin_valid;
    logic                pin_value;

    // When set, neither side idles.
    logic                calm;

    // Predictor copy of the adjacency matrix and the answers still owed.
    logic [NV-1:0]       graph_rows [NV];
    logic                reach_owed [$];

    int                  err_count;
    int                  items_sent;
    int                  queries_seen;
    int                  hits_seen;
    int                  quiet_cycles;

    graph_reachability_bfs_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reachable     (reachable)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Level-by-level search from the entrance. The exit counts only if some walk of at
    // least one edge lands on it.
    function automatic logic bfs_reaches(input logic [VERTEX_W-1:0] entrance,
                                         input logic [VERTEX_W-1:0] exit_v);
        logic [NV-1:0] seen;
        logic [NV-1:0] wave;
        logic [NV-1:0] grow;
        if (entrance >= NV || exit_v >= NV)
            return 1'b0;
        seen = graph_rows[entrance];
        wave = seen;
        for (int lvl = 0; lvl < NV && wave != '0; lvl++)
        begin
            grow = '0;
            for (int v = 0; v < NV; v++)
                if (wave[v])
                    grow |= graph_rows[v];
            wave = grow & ~seen;
            seen |= wave;
        end
        return seen[exit_v];
    endfunction

    function automatic int draw_gap();
        if (calm)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    // Track accepted input beats in the predictor and check accepted output beats.
    always @(posedge clk)
    begin : monitor
        logic want;
        logic got_any;
        got_any = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                got_any = 1'b1;
                case (mode)
                    MODE_CLEAR:
                    begin
                        for (int v = 0; v < NV; v++)
                            graph_rows[v] = '0;
                    end
                    MODE_ADD:
                    begin
                        if (first_vertex < NV && second_vertex < NV)
                        begin
                            graph_rows[first_vertex][second_vertex] = 1'b1;
                            graph_rows[second_vertex][first_vertex] = 1'b1;
                        end
                    end
                    MODE_QUERY:
                    begin
                        want = bfs_reaches(first_vertex, second_vertex);
                        if (pin_valid)
                            want = pin_value;
                        reach_owed.push_back(want);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && out_ready)
            begin
                got_any = 1'b1;
                if (reach_owed.size() == 0)
                begin
                    $error("result beat with no query waiting: reachable=%0b", reachable);
                    err_count++;
                end
                else
                begin
                    want = reach_owed.pop_front();
                    queries_seen++;
                    if (reachable)
                        hits_seen++;
                    if (reachable !== want)
                    begin
                        $error("reachable mismatch: expected %0b, actual %0b", want, reachable);
                        err_count++;
                    end
                end
            end
        end
        if (got_any)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Watchdog on cycles without any accepted beat.
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Result receiver with random stalls, entered and left at a falling edge.
    initial
    begin : receiver
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Offer one beat after a random gap. Called and left at a falling edge.
    task automatic offer_beat(input logic [MODE_W-1:0] op, input logic [VERTEX_W-1:0] va,
                              input logic [VERTEX_W-1:0] vb, input logic pinned = 1'b0,
                              input logic pin = 1'b0);
        int gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= op;
        first_vertex  <= va;
        second_vertex <= vb;
        pin_valid     <= pinned;
        pin_value     <= pin;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        if (op != MODE_SPARE)
            items_sent++;
    endtask

    function automatic logic [VERTEX_W-1:0] any_vertex();
        return VERTEX_W'($urandom_range(0, NV - 1));
    endfunction

    // One round of random traffic: usually a fresh graph, then queries against it.
    task automatic graph_round();
        int kind;
        int len;
        int nq;
        int j;
        logic [VERTEX_W-1:0] order [NV];
        logic [VERTEX_W-1:0] tmp;
        logic [VERTEX_W-1:0] va;
        logic [VERTEX_W-1:0] vb;
        kind = $urandom_range(0, 9);
        calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) != 0)
            offer_beat(MODE_CLEAR, any_vertex(), any_vertex());
        if (kind < 4)
        begin
            // A simple path through shuffled vertices, long enough for deep searches.
            for (int i = 0; i < NV; i++)
                order[i] = VERTEX_W'(i);
            for (int i = NV - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            len = ($urandom_range(0, 3) == 0) ? NV : $urandom_range(2, NV);
            for (int i = 0; i < len - 1; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    offer_beat(MODE_SPARE, any_vertex(), any_vertex());
                if ($urandom_range(0, 1))
                    offer_beat(MODE_ADD, order[i], order[i + 1]);
                else
                    offer_beat(MODE_ADD, order[i + 1], order[i]);
            end
            nq = $urandom_range(2, 6);
            for (int q = 0; q < nq; q++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    va = order[0];
                    vb = order[len - 1];
                end
                else
                begin
                    va = order[$urandom_range(0, len - 1)];
                    vb = any_vertex();
                end
                if ($urandom_range(0, 1))
                    offer_beat(MODE_QUERY, va, vb);
                else
                    offer_beat(MODE_QUERY, vb, va);
            end
        end
        else if (kind < 8)
        begin
            // A random scatter of edges, sparse or dense.
            len = $urandom_range(0, 24);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    offer_beat(MODE_SPARE, any_vertex(), any_vertex());
                offer_beat(MODE_ADD, any_vertex(), any_vertex());
            end
            nq = $urandom_range(2, 8);
            for (int q = 0; q < nq; q++)
                offer_beat(MODE_QUERY, any_vertex(), any_vertex());
        end
        else
        begin
            // Noise: any mode code with any payload.
            len = $urandom_range(3, 10);
            for (int i = 0; i < len; i++)
                offer_beat(MODE_W'($urandom_range(0, 3)), any_vertex(), any_vertex());
        end
    endtask

    // Reset, directed table, random rounds, drain and verdict.
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_CLEAR;
        first_vertex  = '0;
        second_vertex = '0;
        pin_valid     = 1'b0;
        pin_value     = 1'b0;
        calm          = 1'b0;
        err_count     = 0;
        items_sent    = 0;
        queries_seen  = 0;
        hits_seen     = 0;
        quiet_cycles  = 0;
        for (int v = 0; v < NV; v++)
            graph_rows[v] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIRECTED_COUNT; r++)
            offer_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].va, DIRECTED_ROWS[r].vb,
                       DIRECTED_ROWS[r].pinned, DIRECTED_ROWS[r].pin);

        while (items_sent < ITEM_TARGET)
            graph_round();

        in_valid  <= 1'b0;
        pin_valid <= 1'b0;
        calm      = 1'b0;

        // Let every owed answer arrive, then watch for stray beats.
        while (reach_owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d graph beats (clears, edge adds, queries) with idle gaps of 0..%0d.",
                 items_sent, GAP_MAX);
        $display("Checked %0d query answers, %0d of them reachable.", queries_seen, hits_seen);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
design/gbfs_pkg.sv
design/gbfs_cell.sv
design/graph_reachability_bfs_top.sv
dv/testbench.sv
